// ===== hdl/smsc_pkg.sv =====
package smsc_pkg;

  typedef logic [31:0] pos_t;
  typedef logic [15:0] speed_t;

  typedef enum logic [1:0] {
    STATUS_MOVING  = 2'd0,
    STATUS_PASSED  = 2'd1,
    STATUS_REACHED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ADD,
    ST_SQRT,
    ST_EVAL,
    ST_DIVCHK,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = 5;

  localparam logic [RegIdxW-1:0] REG_TARGET_X  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_TARGET_Y  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_SPEED = 3'd2;
  localparam logic [RegIdxW-1:0] REG_BRAKE     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_REVERSE   = 3'd4;

  // 0.01 m in q16.16 and 0.005 in q4.12
  localparam logic [31:0] NEAR_LIMIT   = 32'd655;
  localparam logic [15:0] SPEED_OFFSET = 16'd20;

  localparam logic [14:0] MAX_SPEED_RST = 15'd4096;
  localparam logic [30:0] BRAKE_RST     = 31'd65536;

endpackage

// ===== hdl/smsc_if.sv =====
interface smsc_pose_if;
  logic              valid;
  logic              ready;
  smsc_pkg::pos_t    pose_x;
  smsc_pkg::pos_t    pose_y;

  modport source (output valid, output pose_x, output pose_y, input ready);
  modport sink   (input valid, input pose_x, input pose_y, output ready);
endinterface

interface smsc_speed_if;
  logic              valid;
  logic              ready;
  smsc_pkg::speed_t  wheel_speed;
  logic [1:0]        move_status;

  modport source (output valid, output wheel_speed, output move_status, input ready);
  modport sink   (input valid, input wheel_speed, input move_status, output ready);
endinterface

// ===== hdl/straight_move_speed_controller.sv =====
// channel   dir  word                       handshake
// pose_i    in   pose_x, pose_y (q16.16)    valid/ready
// speed_o   out  wheel_speed (q4.12), status valid/ready
// apb       in   target, speed, brake, rev  psel/penable, pready always high
//
// one word is squared on one 32x32 multiplier, then takes 32 sqrt steps and,
// when moving, an overflow check and the divide steps; sqrt, check and divide
// share one 35-bit subtractor. A quotient that overflows 15 bits skips the
// divide steps, and a stopped word skips both check and divide.
// rst_ni is asynchronous, active low; the closest distance resets to all ones.
// pose_i is not ready while a word is in work; a finished result waits in the
// output register while the next word is taken and worked on.
module straight_move_speed_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  smsc_pose_if.sink                        pose_i,
  smsc_speed_if.source                     speed_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [smsc_pkg::AddrW-1:0]       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // configuration
  logic [31:0] tgt_x_q, tgt_y_q;
  logic [14:0] max_speed_q;
  logic [30:0] brake_q;
  logic        reverse_q;
  logic        cfg_wr;
  logic [smsc_pkg::RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      max_speed_q <= smsc_pkg::MAX_SPEED_RST;
      brake_q     <= smsc_pkg::BRAKE_RST;
      reverse_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        smsc_pkg::REG_TARGET_X:  tgt_x_q     <= pwdata;
        smsc_pkg::REG_TARGET_Y:  tgt_y_q     <= pwdata;
        smsc_pkg::REG_MAX_SPEED: max_speed_q <= pwdata[14:0];
        smsc_pkg::REG_BRAKE:     brake_q     <= pwdata[30:0];
        smsc_pkg::REG_REVERSE:   reverse_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      smsc_pkg::REG_TARGET_X:  prdata = tgt_x_q;
      smsc_pkg::REG_TARGET_Y:  prdata = tgt_y_q;
      smsc_pkg::REG_MAX_SPEED: prdata = {17'd0, max_speed_q};
      smsc_pkg::REG_BRAKE:     prdata = {1'b0, brake_q};
      smsc_pkg::REG_REVERSE:   prdata = {31'd0, reverse_q};
      default:                 prdata = '0;
    endcase
  end

  // sequencer
  smsc_pkg::state_e state_q, state_d;
  logic [4:0]  cnt_q;
  logic        in_acc, load_out;
  logic        out_valid_q;
  logic [15:0] out_speed_q;
  logic [1:0]  out_status_q;
  logic [31:0] closest_q;

  // datapath
  logic [31:0] ax_q, ay_q;
  logic [63:0] prod_q;
  logic [64:0] sum_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [31:0] dist_q;
  logic [33:0] div_q;
  logic [14:0] lo_q;
  logic        ovf_q;
  smsc_pkg::status_e status_q;

  // shared subtractor
  logic [34:0] alu_a, alu_b;
  logic [35:0] alu_diff;
  logic        alu_ge;

  always_comb begin
    unique case (state_q)
      smsc_pkg::ST_SQRT: begin
        alu_a = {rem_q[32:0], sum_q[63:62]};
        alu_b = {1'b0, root_q, 2'b01};
      end
      smsc_pkg::ST_DIVCHK: begin
        alu_a = {6'd0, dist_q[31:3]};
        alu_b = {1'b0, div_q};
      end
      smsc_pkg::ST_DIV: begin
        alu_a = {rem_q[33:0], lo_q[14]};
        alu_b = {1'b0, div_q};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = ~alu_diff[35];

  // absolute differences at accept
  logic [32:0] dx, dy, adx, ady;
  assign dx  = {pose_i.pose_x[31], pose_i.pose_x} - {tgt_x_q[31], tgt_x_q};
  assign dy  = {pose_i.pose_y[31], pose_i.pose_y} - {tgt_y_q[31], tgt_y_q};
  assign adx = dx[32] ? (33'd0 - dx) : dx;
  assign ady = dy[32] ? (33'd0 - dy) : dy;

  logic [31:0] mult_op;
  logic [63:0] mult_res;
  assign mult_op  = (state_q == smsc_pkg::ST_SQX) ? ax_q : ay_q;
  assign mult_res = mult_op * mult_op;

  // distance evaluation
  logic [31:0] dist_cur;
  logic [31:0] closest_new;
  logic        passed, reached;
  logic [30:0] brake_eff;
  assign dist_cur    = sum_q[64] ? '1 : root_q;
  assign closest_new = (dist_cur < closest_q) ? dist_cur : closest_q;
  assign passed      = {1'b0, dist_cur} > ({1'b0, closest_new} + {1'b0, smsc_pkg::NEAR_LIMIT});
  assign reached     = dist_cur <= smsc_pkg::NEAR_LIMIT;
  assign brake_eff   = (brake_q == '0) ? 31'd1 : brake_q;

  // speed from the quotient
  logic [15:0] qsum, qclip, speed;
  assign qsum  = {1'b0, root_q[14:0]} + smsc_pkg::SPEED_OFFSET;
  assign qclip = (ovf_q || qsum > {1'b0, max_speed_q}) ? {1'b0, max_speed_q} : qsum;
  assign speed = (status_q != smsc_pkg::STATUS_MOVING) ? 16'd0 :
                 reverse_q ? (16'd0 - qclip) : qclip;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smsc_pkg::ST_IDLE:   if (in_acc) state_d = smsc_pkg::ST_SQX;
      smsc_pkg::ST_SQX:    state_d = smsc_pkg::ST_SQY;
      smsc_pkg::ST_SQY:    state_d = smsc_pkg::ST_ADD;
      smsc_pkg::ST_ADD:    state_d = smsc_pkg::ST_SQRT;
      smsc_pkg::ST_SQRT:   if (cnt_q == '0) state_d = smsc_pkg::ST_EVAL;
      smsc_pkg::ST_EVAL: begin
        if (passed || reached) state_d = smsc_pkg::ST_DONE;
        else                   state_d = smsc_pkg::ST_DIVCHK;
      end
      smsc_pkg::ST_DIVCHK: state_d = alu_ge ? smsc_pkg::ST_DONE : smsc_pkg::ST_DIV;
      smsc_pkg::ST_DIV:    if (cnt_q == '0) state_d = smsc_pkg::ST_DONE;
      smsc_pkg::ST_DONE:   if (load_out) state_d = smsc_pkg::ST_IDLE;
      default:             state_d = smsc_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pose_i.ready = (state_q == smsc_pkg::ST_IDLE);
    load_out     = (state_q == smsc_pkg::ST_DONE) && (!out_valid_q || speed_o.ready);
  end

  assign in_acc = pose_i.valid & pose_i.ready;

  assign speed_o.valid       = out_valid_q;
  assign speed_o.wheel_speed = out_speed_q;
  assign speed_o.move_status = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smsc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      closest_q   <= '1;
    end else begin
      state_q <= state_d;
      if (state_q == smsc_pkg::ST_ADD)    cnt_q <= 5'd31;
      else if (state_q == smsc_pkg::ST_DIVCHK) cnt_q <= 5'd14;
      else if (cnt_q != '0 && (state_q == smsc_pkg::ST_SQRT ||
                               state_q == smsc_pkg::ST_DIV)) cnt_q <= cnt_q - 5'd1;
      if (state_q == smsc_pkg::ST_EVAL) closest_q <= closest_new;
      if (load_out)            out_valid_q <= 1'b1;
      else if (speed_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q <= adx[31:0];
      ay_q <= ady[31:0];
    end
    unique case (state_q)
      smsc_pkg::ST_SQX: prod_q <= mult_res;
      smsc_pkg::ST_SQY: begin
        sum_q  <= {1'b0, prod_q};
        prod_q <= mult_res;
      end
      smsc_pkg::ST_ADD: begin
        sum_q  <= {1'b0, sum_q[63:0]} + {1'b0, prod_q};
        rem_q  <= '0;
        root_q <= '0;
      end
      smsc_pkg::ST_SQRT: begin
        // keep the overflow bit, feed two radicand bits per step
        sum_q <= {sum_q[64], sum_q[61:0], 2'b00};
        if (alu_ge) begin
          rem_q  <= alu_diff[34:0];
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= alu_a;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      smsc_pkg::ST_EVAL: begin
        dist_q   <= dist_cur;
        div_q    <= {1'b0, brake_eff, 2'b00} + {2'b00, brake_eff, 1'b0};
        status_q <= passed  ? smsc_pkg::STATUS_PASSED :
                    reached ? smsc_pkg::STATUS_REACHED : smsc_pkg::STATUS_MOVING;
      end
      smsc_pkg::ST_DIVCHK: begin
        // a quotient that does not fit in 15 bits saturates at max speed
        ovf_q  <= alu_ge;
        rem_q  <= alu_a;
        lo_q   <= {dist_q[2:0], 12'd0};
        root_q <= '0;
      end
      smsc_pkg::ST_DIV: begin
        lo_q <= {lo_q[13:0], 1'b0};
        if (alu_ge) begin
          rem_q  <= alu_diff[34:0];
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= alu_a;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_speed_q  <= speed;
      out_status_q <= status_q;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == smsc_pkg::ST_SQX)
    else $error("accepted word did not start squaring");

  a_closest_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 closest_q <= $past(closest_q))
    else $error("closest distance grew");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != smsc_pkg::STATUS_MOVING) |-> out_speed_q == 16'd0)
    else $error("stopped result with nonzero speed");

endmodule

// ===== test/straight_move_speed_controller_test.sv =====
module straight_move_speed_controller_test;

  localparam int unsigned LimitCycles = 400000;
  localparam longint PosMax = (64'sd1 <<< 31) - 1;
  localparam longint PosMin = -(64'sd1 <<< 31);

  typedef struct packed {
    smsc_pkg::speed_t  wheel_speed;
    smsc_pkg::status_e move_status;
  } speed_word_t;

  typedef struct packed {
    smsc_pkg::pos_t x;
    smsc_pkg::pos_t y;
  } pose_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [smsc_pkg::AddrW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  smsc_pose_if  pose_if ();
  smsc_speed_if speed_if ();

  straight_move_speed_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pose_i  (pose_if),
    .speed_o (speed_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // own copy of the controller state and registers
  smsc_pkg::pos_t tgt_x;
  smsc_pkg::pos_t tgt_y;
  logic [14:0]    top_speed;
  logic [30:0]    brake_dist;
  logic           rev;
  logic [31:0]    closest_dist;

  speed_word_t speed_q[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          error_count;
  logic [63:0] plan_d;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if ({32'd0, t} * {32'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] dist_to_target(smsc_pkg::pos_t px, smsc_pkg::pos_t py);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [65:0]        sum;
    dx = $signed({px[31], px}) - $signed({tgt_x[31], tgt_x});
    dy = $signed({py[31], py}) - $signed({tgt_y[31], tgt_y});
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    sum = {33'd0, ax} * {33'd0, ax} + {33'd0, ay} * {33'd0, ay};
    // anything past (2^32-1)^2 saturates
    if (sum > 66'hFFFF_FFFE_0000_0001) return 32'hFFFF_FFFF;
    return isqrt(sum[63:0]);
  endfunction

  function automatic speed_word_t predict_speed(smsc_pkg::pos_t px, smsc_pkg::pos_t py);
    logic [31:0] d;
    logic [63:0] brk;
    logic [63:0] q;
    speed_word_t w;
    d = dist_to_target(px, py);
    if (d < closest_dist) closest_dist = d;
    w.wheel_speed = '0;
    if ({32'd0, d} > {32'd0, closest_dist} + 64'(smsc_pkg::NEAR_LIMIT)) begin
      w.move_status = smsc_pkg::STATUS_PASSED;
    end else if (d <= smsc_pkg::NEAR_LIMIT) begin
      w.move_status = smsc_pkg::STATUS_REACHED;
    end else begin
      brk = (brake_dist == '0) ? 64'd1 : {33'd0, brake_dist};
      q = ({32'd0, d} << 12) / (64'd6 * brk) + 64'(smsc_pkg::SPEED_OFFSET);
      if (q > {49'd0, top_speed}) q = {49'd0, top_speed};
      w.wheel_speed = rev ? 16'(64'd0 - q) : q[15:0];
      w.move_status = smsc_pkg::STATUS_MOVING;
    end
    return w;
  endfunction

  // step away from base by off, in whichever direction stays in range
  function automatic smsc_pkg::pos_t offset_pos(smsc_pkg::pos_t base, logic [63:0] off);
    longint b;
    longint o;
    longint v;
    b = signed'(base);
    o = longint'(off);
    v = $urandom_range(1) ? b + o : b - o;
    if (v > PosMax || v < PosMin) v = (v > b) ? b - o : b + o;
    if (v > PosMax) v = PosMax;
    if (v < PosMin) v = PosMin;
    return v[31:0];
  endfunction

  // pose at about distance d from the target, random direction
  function automatic pose_t pose_at(logic [63:0] d);
    logic [63:0] ax;
    logic [63:0] ay;
    pose_t       p;
    ax = {$urandom, $urandom} % (d + 64'd1);
    ay = {32'd0, isqrt(d * d - ax * ax)};
    p.x = offset_pos(tgt_x, ax);
    p.y = offset_pos(tgt_y, ay);
    return p;
  endfunction

  function automatic pose_t axis_pose(logic [63:0] d);
    pose_t p;
    p.x = tgt_x + d[31:0];
    p.y = tgt_y;
    return p;
  endfunction

  task automatic send_pose(pose_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pose_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pose_if.valid  <= 1'b1;
    pose_if.pose_x <= p.x;
    pose_if.pose_y <= p.y;
    @(posedge clk_i);
    while (!pose_if.ready) @(posedge clk_i);
    speed_q.push_back(predict_speed(p.x, p.y));
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    pose_if.valid <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [smsc_pkg::RegIdxW-1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= smsc_pkg::AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      smsc_pkg::REG_TARGET_X:  tgt_x = data;
      smsc_pkg::REG_TARGET_Y:  tgt_y = data;
      smsc_pkg::REG_MAX_SPEED: top_speed = data[14:0];
      smsc_pkg::REG_BRAKE:     brake_dist = data[30:0];
      smsc_pkg::REG_REVERSE:   rev = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_far_corner();
    cfg_write(smsc_pkg::REG_TARGET_X, 32'h8000_0000);
    cfg_write(smsc_pkg::REG_TARGET_Y, 32'h8000_0000);
    // opposite corner: sum of squares overflows, distance saturates
    send_pose('{x: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF});
    send_pose('{x: 32'h7FFF_FFFF, y: 32'h8000_0000});
    send_pose('{x: 32'h8000_0000, y: 32'h7FFF_FFFF});
  endtask

  task automatic test_speed_limits();
    drain();
    cfg_write(smsc_pkg::REG_MAX_SPEED, 32'd32767);
    cfg_write(smsc_pkg::REG_REVERSE, 32'd1);
    cfg_write(smsc_pkg::REG_BRAKE, 32'h7FFF_FFFF);
    send_pose(axis_pose(64'hFFFF_FFF0));
    drain();
    cfg_write(smsc_pkg::REG_MAX_SPEED, 32'd0);
    send_pose(axis_pose(64'hFFFF_FF00));
    drain();
    // zero braking distance acts as one
    cfg_write(smsc_pkg::REG_MAX_SPEED, 32'd32767);
    cfg_write(smsc_pkg::REG_REVERSE, 32'd0);
    cfg_write(smsc_pkg::REG_BRAKE, 32'd0);
    send_pose(axis_pose(64'hFFFF_FE00));
    drain();
    cfg_write(smsc_pkg::REG_BRAKE, 32'd1);
    send_pose(axis_pose(64'hFFFF_FD00));
  endtask

  task automatic test_pass_margin();
    logic [63:0] c;
    drain();
    cfg_write(smsc_pkg::REG_BRAKE, 32'h0100_0000);
    cfg_write(smsc_pkg::REG_MAX_SPEED, 32'd20000);
    cfg_write(smsc_pkg::REG_REVERSE, 32'd1);
    c = {32'd0, closest_dist};
    send_pose(axis_pose(c - 64'd1000 + 64'd655));
    c = {32'd0, closest_dist};
    // exactly at the margin still moves, one past it is a pass
    send_pose(axis_pose(c + 64'd655));
    send_pose(axis_pose(c + 64'd656));
    send_pose(axis_pose(c - 64'd1));
  endtask

  task automatic retune_for_distance();
    logic [63:0] brk;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] ms;
    int          r;
    drain();
    if (plan_d > 64'h7FFF_FFFF) begin
      tx = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      ty = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      tx = $urandom;
      ty = $urandom;
    end
    // aim the braking distance so the ratio lands around the speed range
    r = $urandom_range(40000, 1);
    brk = (plan_d << 12) / (64'd6 * r);
    if (brk == 0) brk = 64'd1;
    if (brk > 64'h7FFF_FFFF) brk = 64'h7FFF_FFFF;
    case ($urandom_range(9))
      0:       ms = 32'd0;
      1:       ms = 32'd32767;
      default: ms = $urandom_range(32767);
    endcase
    cfg_write(smsc_pkg::REG_TARGET_X, tx);
    cfg_write(smsc_pkg::REG_TARGET_Y, ty);
    cfg_write(smsc_pkg::REG_MAX_SPEED, ms);
    cfg_write(smsc_pkg::REG_BRAKE, brk[31:0]);
    cfg_write(smsc_pkg::REG_REVERSE, $urandom_range(1));
  endtask

  task automatic test_random_descent(int n_items);
    pose_t       p;
    logic [63:0] d;
    int          pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) retune_for_distance();
      pick = $urandom_range(99);
      if (pick < 80) begin
        // approach: shrink the distance, sometimes back off within the margin
        plan_d = plan_d - (plan_d >> $urandom_range(8, 4));
        d = ($urandom_range(3) == 0) ? plan_d + $urandom_range(655) : plan_d;
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
        p = pose_at(d);
      end else if (pick < 90) begin
        d = plan_d + 64'd656 + (plan_d >> $urandom_range(6));
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
        p = pose_at(d);
      end else begin
        p.x = $urandom;
        p.y = $urandom;
      end
      send_pose(p);
    end
  endtask

  task automatic test_arrival();
    logic [31:0] tx;
    logic [31:0] ty;
    int unsigned near_steps[10] = '{1310, 700, 656, 655, 700, 1311, 0, 655, 656, 300};
    drain();
    tx = $urandom;
    ty = $urandom;
    tx[30] = tx[31];
    ty[30] = ty[31];
    cfg_write(smsc_pkg::REG_TARGET_X, tx);
    cfg_write(smsc_pkg::REG_TARGET_Y, ty);
    cfg_write(smsc_pkg::REG_BRAKE, 32'd1000);
    cfg_write(smsc_pkg::REG_MAX_SPEED, 32'd32767);
    cfg_write(smsc_pkg::REG_REVERSE, $urandom_range(1));
    plan_d = {32'd0, closest_dist};
    while (plan_d > 64'd2000) begin
      plan_d = plan_d >> 1;
      send_pose(pose_at(plan_d));
    end
    // reach, then keep going: each word is judged again
    foreach (near_steps[i]) send_pose(axis_pose(64'(near_steps[i])));
  endtask

  always @(posedge clk_i) begin : speed_check
    speed_word_t exp_w;
    if (rst_ni) begin
      if (speed_if.valid && speed_if.ready) begin
        if (speed_q.size() == 0) begin
          $display("%0t: unexpected word: speed %h status %0d", $time,
                   speed_if.wheel_speed, speed_if.move_status);
          error_count++;
        end else begin
          exp_w = speed_q.pop_front();
          if (speed_if.wheel_speed !== exp_w.wheel_speed) begin
            $display("%0t: wheel_speed expected %h actual %h", $time,
                     exp_w.wheel_speed, speed_if.wheel_speed);
            error_count++;
          end
          if (speed_if.move_status !== exp_w.move_status) begin
            $display("%0t: move_status expected %0d actual %0d", $time,
                     exp_w.move_status, speed_if.move_status);
            error_count++;
          end
        end
      end
      speed_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #(LimitCycles * 20);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pose_if.valid  = 1'b0;
    pose_if.pose_x = '0;
    pose_if.pose_y = '0;
    speed_if.ready = 1'b0;
    tgt_x          = '0;
    tgt_y          = '0;
    top_speed      = smsc_pkg::MAX_SPEED_RST;
    brake_dist     = smsc_pkg::BRAKE_RST;
    rev            = 1'b0;
    closest_dist   = '1;
    error_count    = 0;
    send_idle_pct  = 23;
    recv_idle_pct  = 58;
    plan_d         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_far_corner();
    test_speed_limits();
    test_pass_margin();

    plan_d = {32'd0, closest_dist};
    test_random_descent(200);
    drain();
    send_idle_pct = 58;
    recv_idle_pct = 23;
    test_random_descent(200);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_descent(200);
    test_arrival();

    drain();
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && speed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== straight_move_speed_controller.f =====
hdl/smsc_pkg.sv
hdl/smsc_if.sv
hdl/straight_move_speed_controller.sv
test/straight_move_speed_controller_test.sv
